/* rtl/sts_pkg.sv */
package sts_pkg;

	localparam int unsigned INDEX_W  = 10;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned LENGTH_W = 11;
	localparam int unsigned STEP_W   = 4;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	// word index of each register, taken from paddr[2]
	localparam logic REG_TABLE_LENGTH = 1'b0;

	typedef struct packed {
		logic                      kind;
		logic [INDEX_W-1:0]        entry_index;
		logic signed [DATA_W-1:0]  entry_value;
		logic signed [DATA_W-1:0]  search_key;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] found_index;
		logic [STEP_W-1:0]  step_count;
	} rsp_t;

endpackage

/* rtl/sts_if.sv */
interface sts_req_if;
	logic          valid;
	logic          ready;
	sts_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sts_rsp_if;
	logic          valid;
	logic          ready;
	sts_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/sts_ram.sv */
module sts_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/sorted_table_binary_search.sv */
// Sorted-table binary search.
// req (sink): one beat is a load (kind = 0) that writes entry_value at
//   entry_index, or a search (kind = 1) for search_key over the first
//   table_length entries. Loads at or beyond TABLE_DEPTH are dropped.
// rsp (source): one beat per search with found, found_index, step_count.
// APB: register 0 (byte address 0) is table_length; searches clamp it to TABLE_DEPTH.
//   Write it only while no search is in flight.
// Flow: a load is taken while idle and leaves req.ready high. A search
//   holds req.ready low through its midpoint compares (ST_SRCH) and the
//   result hand-off (ST_FIN), and the next beat is taken after that. Compares
//   run back to back: the table RAM's registered read data is compared and the
//   next midpoint address goes back to the read port in the same cycle.
//   An empty table goes straight to ST_FIN.
// The result sits in an output register; while rsp stalls, beats keep being
//   taken, but a finished search waits, req.ready low, until the register frees.
// Reset clears table_length and all control state. Table contents are
//   undefined until loaded and must be loaded before they are searched.
module sorted_table_binary_search #(
	parameter int unsigned TABLE_DEPTH = 1024,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sts_req_if.sink                      req,
	sts_rsp_if.source                    rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sts_pkg::PADDR_W-1:0]  paddr,
	input  logic [sts_pkg::PDATA_W-1:0]  pwdata,
	output logic [sts_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SRCH = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]                      state_q;
	logic [sts_pkg::LENGTH_W-1:0]    table_length_q;
	logic                            rsp_valid_q;
	sts_pkg::rsp_t                   rsp_data_q;
	sts_pkg::rsp_t                   res_q;

	logic [AW:0]                     lo_q;
	logic [AW:0]                     hix_q;
	logic [AW-1:0]                   mid_q;
	logic [VALUE_WIDTH-1:0]          key_q;
	logic [sts_pkg::STEP_W-1:0]      steps_q;

	logic                            cfg_wr;
	logic                            req_acc;
	logic                            is_search;
	logic [31:0]                     idx32;
	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [VALUE_WIDTH-1:0]          ram_wdata;
	logic                            ram_re;
	logic [AW-1:0]                   ram_raddr;
	logic [VALUE_WIDTH-1:0]          ram_rdata;

	logic [31:0]                     tl32;
	logic [31:0]                     len32;
	logic [AW:0]                     lenx;
	logic                            len_zero;
	logic [AW:0]                     mid0_x;

	logic                            eq;
	logic                            gt;
	logic [AW:0]                     mid_x;
	logic [AW:0]                     lo_n;
	logic [AW:0]                     hi_n;
	logic [AW:0]                     mid_n_x;
	logic                            empty;
	logic [sts_pkg::STEP_W-1:0]      steps_n;
	logic [31:0]                     mid32;
	logic                            slot_free;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		if (paddr[2] == sts_pkg::REG_TABLE_LENGTH) begin
			prdata = sts_pkg::PDATA_W'(table_length_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= '0;
		end else if (cfg_wr && paddr[2] == sts_pkg::REG_TABLE_LENGTH) begin
			table_length_q <= pwdata[sts_pkg::LENGTH_W-1:0];
		end
	end

	// input side
	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign is_search = (req.data.kind == sts_pkg::KIND_SEARCH);

	assign idx32     = 32'(req.data.entry_index);
	assign ram_we    = req_acc && !is_search && (idx32 < TABLE_DEPTH);
	assign ram_waddr = idx32[AW-1:0];
	assign ram_wdata = VALUE_WIDTH'(req.data.entry_value);

	assign tl32     = 32'(table_length_q);
	assign len32    = (tl32 > TABLE_DEPTH) ? TABLE_DEPTH : tl32;
	assign lenx     = len32[AW:0];
	assign len_zero = (lenx == '0);
	assign mid0_x   = (lenx - 1'b1) >> 1;

	// one compare per cycle against the registered read data
	assign eq      = (ram_rdata == key_q);
	assign gt      = $signed(ram_rdata) > $signed(key_q);
	assign mid_x   = {1'b0, mid_q};
	assign lo_n    = gt ? lo_q : (mid_x + 1'b1);
	assign hi_n    = gt ? mid_x : hix_q;
	assign empty   = !(lo_n < hi_n);
	assign mid_n_x = lo_n + ((hi_n - lo_n - 1'b1) >> 1);
	assign steps_n = steps_q + 1'b1;
	assign mid32   = 32'(mid_q);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = mid_n_x[AW-1:0];
		if (state_q == ST_IDLE) begin
			ram_re    = req_acc && is_search && !len_zero;
			ram_raddr = mid0_x[AW-1:0];
		end else if (state_q == ST_SRCH) begin
			ram_re = !eq && !empty;
		end
	end

	sts_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign slot_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc && is_search) begin
						state_q <= len_zero ? ST_FIN : ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (eq || empty) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_acc && is_search) begin
			key_q   <= VALUE_WIDTH'(req.data.search_key);
			lo_q    <= '0;
			hix_q   <= lenx;
			mid_q   <= mid0_x[AW-1:0];
			steps_q <= '0;
			res_q   <= '0;
		end else if (state_q == ST_SRCH) begin
			steps_q <= steps_n;
			lo_q    <= lo_n;
			hix_q   <= hi_n;
			mid_q   <= mid_n_x[AW-1:0];
			if (eq) begin
				res_q.found       <= 1'b1;
				res_q.found_index <= mid32[sts_pkg::INDEX_W-1:0];
				res_q.step_count  <= steps_n;
			end else if (empty) begin
				res_q.found       <= 1'b0;
				res_q.found_index <= '0;
				res_q.step_count  <= steps_n;
			end
		end
		if (state_q == ST_FIN && slot_free) begin
			rsp_data_q <= res_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

/* sim/sorted_table_binary_search_tb.sv */
module sorted_table_binary_search_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH         = 1024;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 560;
	localparam int QUIET_TAIL    = 200;

	localparam logic [sts_pkg::PADDR_W-1:0] LENGTH_ADDR =
		{sts_pkg::REG_TABLE_LENGTH, 2'b00};
	localparam logic [sts_pkg::PADDR_W-1:0] UNMAPPED_ADDR =
		{~sts_pkg::REG_TABLE_LENGTH, 2'b00};

	localparam logic signed [sts_pkg::DATA_W-1:0] VAL_MIN =
		{1'b1, {(sts_pkg::DATA_W-1){1'b0}}};
	localparam logic signed [sts_pkg::DATA_W-1:0] VAL_MAX =
		{1'b0, {(sts_pkg::DATA_W-1){1'b1}}};

	typedef enum logic [1:0] {ROW_LOAD, ROW_SEARCH, ROW_LENGTH} row_op_t;

	typedef struct packed {
		row_op_t                     op;
		logic [sts_pkg::INDEX_W-1:0] idx;
		logic [sts_pkg::DATA_W-1:0]  val;
		logic                        pinned;
		sts_pkg::rsp_t               want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [sts_pkg::PADDR_W-1:0] paddr;
	logic [sts_pkg::PDATA_W-1:0] pwdata;
	logic [sts_pkg::PDATA_W-1:0] prdata;
	logic                        pready;

	sts_req_if req_bus();
	sts_rsp_if rsp_bus();

	sorted_table_binary_search dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_bus),
		.rsp     (rsp_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	logic signed [sts_pkg::DATA_W-1:0] sorted_copy [0:DEPTH-1];
	logic [sts_pkg::LENGTH_W-1:0]      length_reg;
	sts_pkg::rsp_t                     lookup_due [$];
	plan_row_t                         plan [$];

	bit idle_on = 1'b1;
	int beats_sent;
	int loads_sent;
	int searches_sent;
	int hits_seen;
	int deepest;
	int lengths_tried;
	int mismatches;

	function automatic sts_pkg::rsp_t search_table(
			input logic signed [sts_pkg::DATA_W-1:0] key);
		sts_pkg::rsp_t r;
		int lo;
		int hi;
		int mid;
		r = '0;
		lo = 0;
		hi = ((length_reg > DEPTH) ? DEPTH : int'(length_reg)) - 1;
		while (lo <= hi && !r.found) begin
			mid = lo + (hi - lo) / 2;
			r.step_count = r.step_count + 1'b1;
			if (sorted_copy[mid] == key) begin
				r.found = 1'b1;
				r.found_index = mid[sts_pkg::INDEX_W-1:0];
			end else if (sorted_copy[mid] > key) begin
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		return r;
	endfunction

	function automatic logic signed [sts_pkg::DATA_W-1:0] pick_key();
		int span;
		logic signed [sts_pkg::DATA_W-1:0] probe;
		span = (length_reg > DEPTH) ? DEPTH : int'(length_reg);
		probe = (span > 0) ? sorted_copy[$urandom_range(0, span - 1)] : $urandom;
		case ($urandom_range(0, 9))
			6: return probe + 1;
			7: return probe - 1;
			8: return $urandom;
			9: return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
			default: return probe;
		endcase
	endfunction

	function automatic void plan_row(input row_op_t op, input int idx,
			input logic [sts_pkg::DATA_W-1:0] val, input int pinned, input int hit,
			input int where, input int steps);
		plan_row_t r;
		r.op = op;
		r.idx = idx[sts_pkg::INDEX_W-1:0];
		r.val = val;
		r.pinned = (pinned != 0);
		r.want.found = (hit != 0);
		r.want.found_index = where[sts_pkg::INDEX_W-1:0];
		r.want.step_count = steps[sts_pkg::STEP_W-1:0];
		plan.push_back(r);
	endfunction

	task automatic send_beat(input sts_pkg::req_t item, input logic pinned,
			input sts_pkg::rsp_t pinned_rsp);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.data <= item;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		beats_sent++;
		if (item.kind == sts_pkg::KIND_LOAD) begin
			sorted_copy[item.entry_index] = item.entry_value;
			loads_sent++;
		end else begin
			lookup_due.push_back(pinned ? pinned_rsp : search_table(item.search_key));
			searches_sent++;
		end
	endtask

	task automatic drain_results();
		req_bus.valid <= 1'b0;
		do @(posedge clk); while (lookup_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sts_pkg::PADDR_W-1:0] addr,
			input logic [sts_pkg::PDATA_W-1:0] wdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr[2] == sts_pkg::REG_TABLE_LENGTH) begin
			length_reg = wdata[sts_pkg::LENGTH_W-1:0];
			lengths_tried++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// ascending run between the current neighbors of the window
	task automatic load_sorted_run(input int base_idx, input int count);
		longint floor_v;
		longint ceil_v;
		longint acc;
		longint stride;
		sts_pkg::req_t item;
		floor_v = (base_idx == 0) ? longint'(VAL_MIN) : longint'(sorted_copy[base_idx - 1]);
		ceil_v = (base_idx + count >= DEPTH) ? longint'(VAL_MAX)
			: longint'(sorted_copy[base_idx + count]);
		if (ceil_v < floor_v) ceil_v = floor_v;
		stride = (ceil_v - floor_v) / count;
		acc = floor_v;
		for (int k = 0; k < count; k++) begin
			acc = acc + longint'($urandom_range(0, 32'(stride)));
			item.kind = sts_pkg::KIND_LOAD;
			item.entry_index = sts_pkg::INDEX_W'(base_idx + k);
			item.entry_value = acc[sts_pkg::DATA_W-1:0];
			item.search_key = $urandom;
			send_beat(item, 1'b0, '0);
		end
	endtask

	initial begin : result_monitor
		sts_pkg::rsp_t got;
		sts_pkg::rsp_t want;
		int hold;
		hold = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_bus.valid && rsp_bus.ready) begin
				got = rsp_bus.data;
				if (lookup_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result beat with nothing pending: found=%0d index=%0d steps=%0d",
							got.found, got.found_index, got.step_count);
				end else begin
					want = lookup_due.pop_front();
					if (got.found !== want.found || got.found_index !== want.found_index ||
							got.step_count !== want.step_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected found=%0d index=%0d steps=%0d,",
								" got found=%0d index=%0d steps=%0d"},
								want.found, want.found_index, want.step_count,
								got.found, got.found_index, got.step_count);
					end
					if (want.found) hits_seen++;
					if (int'(want.step_count) > deepest) deepest = int'(want.step_count);
				end
			end
			if (hold > 0) begin
				hold--;
				rsp_bus.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(0, 2);
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || psel || (req_bus.valid && req_bus.ready) ||
					(rsp_bus.valid && rsp_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: %0d idle cycles, %0d results pending",
			quiet, lookup_due.size());
		$display("sorted_table_binary_search regression: fail");
		$finish;
	end

	initial begin : stimulus
		sts_pkg::req_t item;
		plan_row_t row;
		int beat_goal;
		int len;
		int base_idx;
		int count;
		int n_search;
		logic [sts_pkg::PDATA_W-1:0] wdata;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_bus.valid = 1'b0;
		req_bus.data = '0;
		length_reg = '0;

		// empty table after reset, then a five-entry table
		plan_row(ROW_SEARCH, 0, 32'd0,       1, 0, 0, 0);
		plan_row(ROW_SEARCH, 0, VAL_MIN,     1, 0, 0, 0);
		plan_row(ROW_SEARCH, 0, VAL_MAX,     1, 0, 0, 0);
		plan_row(ROW_LOAD,   0, VAL_MIN,     0, 0, 0, 0);
		plan_row(ROW_LOAD,   1, -32'sd7,     0, 0, 0, 0);
		plan_row(ROW_LOAD,   2, 32'd0,       0, 0, 0, 0);
		plan_row(ROW_LOAD,   3, 32'd5,       0, 0, 0, 0);
		plan_row(ROW_LOAD,   4, VAL_MAX,     0, 0, 0, 0);
		plan_row(ROW_LENGTH, int'(LENGTH_ADDR), 32'd5, 0, 0, 0, 0);
		plan_row(ROW_SEARCH, 0, VAL_MIN,     1, 1, 0, 2);
		plan_row(ROW_SEARCH, 0, VAL_MAX,     1, 1, 4, 3);
		plan_row(ROW_SEARCH, 0, -32'sd7,     0, 0, 0, 0);
		plan_row(ROW_SEARCH, 0, 32'd0,       1, 1, 2, 1);
		plan_row(ROW_SEARCH, 0, 32'd6,       1, 0, 0, 3);
		// unmapped register: length must stay at five
		plan_row(ROW_LENGTH, int'(UNMAPPED_ADDR), 32'd1, 0, 0, 0, 0);
		plan_row(ROW_SEARCH, 0, 32'd5,       0, 0, 0, 0);
		plan_row(ROW_LENGTH, int'(LENGTH_ADDR), 32'd1, 0, 0, 0, 0);
		plan_row(ROW_SEARCH, 0, VAL_MIN,     1, 1, 0, 1);
		plan_row(ROW_SEARCH, 0, 32'd1,       1, 0, 0, 1);
		// upper data bits beyond the register are dropped
		plan_row(ROW_LENGTH, int'(LENGTH_ADDR), 32'hFFFF_F802, 0, 0, 0, 0);
		plan_row(ROW_SEARCH, 0, -32'sd7,     0, 0, 0, 0);
		// out-of-order pair
		plan_row(ROW_LOAD,   0, 32'd100,     0, 0, 0, 0);
		plan_row(ROW_LOAD,   1, -32'sd100,   0, 0, 0, 0);
		plan_row(ROW_SEARCH, 0, -32'sd100,   0, 0, 0, 0);
		plan_row(ROW_LENGTH, int'(LENGTH_ADDR), 32'd0, 0, 0, 0, 0);
		plan_row(ROW_SEARCH, 0, 32'd5,       1, 0, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < plan.size(); i++) begin
			row = plan[i];
			case (row.op)
				ROW_LENGTH: begin
					drain_results();
					write_reg(row.idx[sts_pkg::PADDR_W-1:0], row.val);
				end
				ROW_LOAD: begin
					item.kind = sts_pkg::KIND_LOAD;
					item.entry_index = row.idx;
					item.entry_value = row.val;
					item.search_key = $urandom;
					send_beat(item, 1'b0, '0);
				end
				default: begin
					item.kind = sts_pkg::KIND_SEARCH;
					item.entry_index = sts_pkg::INDEX_W'($urandom);
					item.entry_value = $urandom;
					item.search_key = row.val;
					send_beat(item, row.pinned, row.want);
				end
			endcase
		end

		// whole table in ascending order; stray random loads below may break the order again
		load_sorted_run(0, DEPTH);

		beat_goal = beats_sent + RANDOM_ITEMS;
		while (beats_sent < beat_goal) begin
			idle_on = (beats_sent < beat_goal - QUIET_TAIL);

			if ($urandom_range(0, 1) == 0) begin
				count = $urandom_range(1, 24);
				base_idx = $urandom_range(0, DEPTH - count);
				load_sorted_run(base_idx, count);
			end
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					item.kind = sts_pkg::KIND_LOAD;
					item.entry_index = sts_pkg::INDEX_W'($urandom);
					item.entry_value = $urandom;
					item.search_key = $urandom;
					send_beat(item, 1'b0, '0);
				end
			end

			case ($urandom_range(0, 19))
				0: len = 0;
				1: len = DEPTH;
				2: len = $urandom_range(0, 1) ? 2047 : $urandom_range(DEPTH + 1, 2047);
				3, 4, 5: len = $urandom_range(41, DEPTH - 1);
				default: len = $urandom_range(1, 40);
			endcase
			wdata = ($urandom_range(0, 3) == 0) ? $urandom : '0;
			wdata[sts_pkg::LENGTH_W-1:0] = len[sts_pkg::LENGTH_W-1:0];

			drain_results();
			if ($urandom_range(0, 15) == 0) write_reg(UNMAPPED_ADDR, $urandom);
			write_reg(LENGTH_ADDR, wdata);

			n_search = $urandom_range(6, 30);
			repeat (n_search) begin
				if ($urandom_range(0, 39) == 0) drain_results();
				if ($urandom_range(0, 9) == 0)
					load_sorted_run($urandom_range(0, DEPTH - 1), 1);
				item.kind = sts_pkg::KIND_SEARCH;
				item.entry_index = sts_pkg::INDEX_W'($urandom);
				item.entry_value = $urandom;
				item.search_key = pick_key();
				send_beat(item, 1'b0, '0);
			end
		end

		idle_on = 1'b0;
		drain_results();

		$display("covered %0d loads and %0d searches (%0d hits) over %0d length settings",
			loads_sent, searches_sent, hits_seen, lengths_tried);
		$display("deepest search took %0d compares; %0d mismatches", deepest, mismatches);
		if (mismatches == 0)
			$display("sorted_table_binary_search regression: pass");
		else
			$display("sorted_table_binary_search regression: fail");
		$finish;
	end

endmodule

/* sim.f */
rtl/sts_pkg.sv
rtl/sts_if.sv
rtl/sts_ram.sv
rtl/sorted_table_binary_search.sv
sim/sorted_table_binary_search_tb.sv
